>>> rtl/u16tu8_pkg.sv
// ----------------------------------------------------------------------------
// u16tu8_pkg
// Types and constants shared by the UTF-16 to UTF-8 transcoder modules.
// ----------------------------------------------------------------------------
package u16tu8_pkg;

  // Input transfer: one UTF-16 code unit as stored
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  // Output transfer: one UTF-8 byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic        has_pre;   // emit U+FFFD for an unpaired lead first
    logic        has_cp;    // then emit cp
    logic [20:0] cp;
    logic        last;      // flag the final byte of this entry
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [5:0]  LeadPrefix  = 6'b110110;
  localparam logic [5:0]  TrailPrefix = 6'b110111;
  localparam logic [20:0] Replacement = 21'h00FFFD;
  localparam logic [20:0] SuppBase    = 21'h010000;

endpackage

>>> rtl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and U+FFFD
// replacement of unpaired surrogates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one code unit per
//   transfer; last_unit marks the end of a string. Output channel
//   (out_valid_o/out_ready_i/out_data_o) gives one UTF-8 byte per transfer,
//   with last_byte on the final byte of the string.
//   cfg_we_i writes swap_bytes from cfg_wdata_i; write it only while idle.
//   A unit's bytes pass the queue, the entry and the output registers in turn.
//   Throughput: the output runs at one byte per cycle unless out_ready_i
//   stalls it. A unit gives 1 to 4 bytes (up to 6 when an unpaired lead is
//   flushed); the byte serializer in the back end sets the rate. A lead that
//   is held produces nothing until the next unit.
//   A 2-entry queue sits between the classifier and the serializer, so units
//   keep being taken while the output stalls, until the queue fills.
//   Reset clears swap_bytes, the held lead, the queue and the output register.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  u16tu8_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output u16tu8_pkg::out_item_t out_data_o
);
  import u16tu8_pkg::*;

  logic      swap_q;
  logic      push, pop;
  q_entry_t  push_entry, head_entry;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q <= 1'b0;
    end else if (cfg_we_i) begin
      swap_q <= cfg_wdata_i;
    end
  end

  u16tu8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .swap_i     (swap_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  u16tu8_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (q_status)
  );

  u16tu8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // front must never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_status.full)
    else $error("push into full queue");

  // back must never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // bytes that never occur in well-formed UTF-8
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_byte != 8'hC0 && out_data_o.out_byte != 8'hC1 &&
                     out_data_o.out_byte < 8'hF5))
    else $error("ill-formed UTF-8 byte");

  // string end can't land on a multi-byte lead byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_byte) |-> (out_data_o.out_byte[7:6] != 2'b11))
    else $error("last_byte on a lead byte");

endmodule

>>> rtl/u16tu8_front.sv
// ----------------------------------------------------------------------------
// u16tu8_front
// Accepts code units, applies the byte swap, classifies surrogates, holds a
// pending lead and pushes the resulting code points into the queue.
// ----------------------------------------------------------------------------
module u16tu8_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  swap_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  u16tu8_pkg::in_item_t  in_data_i,
  input  u16tu8_pkg::q_status_t q_status_i,
  output logic                  push_o,
  output u16tu8_pkg::q_entry_t  entry_o
);
  import u16tu8_pkg::*;

  logic        pending_q, pending_d;
  logic [9:0]  held_q, held_d;
  logic [15:0] unit;
  logic        is_lead, is_trail, accept;
  q_entry_t    entry;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  assign unit     = swap_i ? {in_data_i.code_unit[7:0], in_data_i.code_unit[15:8]}
                           : in_data_i.code_unit;
  assign is_lead  = (unit[15:10] == LeadPrefix);
  assign is_trail = (unit[15:10] == TrailPrefix);

  always_comb begin
    pending_d     = pending_q;
    held_d        = held_q;
    entry.has_pre = 1'b0;
    entry.has_cp  = 1'b1;
    entry.cp      = {5'd0, unit};
    entry.last    = in_data_i.last_unit;
    if (pending_q && is_trail) begin
      entry.cp = {1'b0, held_q, unit[9:0]} + SuppBase;
    end else begin
      entry.has_pre = pending_q;
      if (is_lead && !in_data_i.last_unit) begin
        entry.has_cp = 1'b0;
      end else if (is_lead || is_trail) begin
        entry.cp = Replacement;
      end
    end
    if (accept) begin
      pending_d = is_lead && !in_data_i.last_unit && !(pending_q && is_trail);
      held_d    = pending_d ? unit[9:0] : 10'd0;
    end
  end

  assign push_o  = accept && (entry.has_pre || entry.has_cp);
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= 10'd0;
    end else begin
      pending_q <= pending_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> rtl/u16tu8_fifo.sv
// ----------------------------------------------------------------------------
// u16tu8_fifo
// Short register queue of classified code points between front and back.
// ----------------------------------------------------------------------------
module u16tu8_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  u16tu8_pkg::q_entry_t  entry_i,
  input  logic                  pop_i,
  output u16tu8_pkg::q_entry_t  entry_o,
  output u16tu8_pkg::q_status_t status_o
);
  import u16tu8_pkg::*;

  q_entry_t           mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign entry_o        = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    next_ptr = (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

>>> rtl/u16tu8_back.sv
// ----------------------------------------------------------------------------
// u16tu8_back
// Pops queued code points and serializes their UTF-8 bytes, one per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module u16tu8_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  u16tu8_pkg::q_entry_t  entry_i,
  input  u16tu8_pkg::q_status_t q_status_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output u16tu8_pkg::out_item_t out_data_o
);
  import u16tu8_pkg::*;

  typedef struct packed {
    logic [3:0][7:0] bytes;   // bytes[0] goes out first
    logic [1:0]      cnt_m1;
  } enc_t;

  function automatic enc_t encode(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
      e.cnt_m1   = 2'd0;
    end else if (cp <= 21'h7FF) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.cnt_m1   = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.cnt_m1   = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.cnt_m1   = 2'd3;
    end
    return e;
  endfunction

  localparam enc_t ReplEnc = encode(Replacement);

  logic       act_q, pre_q, cpv_q, last_q;
  logic [1:0] idx_q;
  enc_t       enc_q, enc_in;
  logic       ov_q;
  out_item_t  od_q;

  logic       adv, step, done, take, flag;
  logic [7:0] byte_sel;

  assign enc_in = encode(entry_i.cp);
  assign adv    = !ov_q || out_ready_i;
  assign step   = adv && act_q;

  always_comb begin
    if (pre_q) begin
      byte_sel = ReplEnc.bytes[idx_q];
      done     = (idx_q == ReplEnc.cnt_m1) && !cpv_q;
      flag     = last_q && done;
    end else begin
      byte_sel = enc_q.bytes[idx_q];
      done     = (idx_q == enc_q.cnt_m1);
      flag     = last_q && done;
    end
  end

  // refill in the cycle the current entry finishes to keep one byte per cycle
  assign take  = (!act_q || (step && done)) && !q_status_i.empty;
  assign pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pre_q <= 1'b0;
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (step) begin
        ov_q <= 1'b1;
      end else if (adv) begin
        ov_q <= 1'b0;
      end
      if (take) begin
        act_q <= 1'b1;
        pre_q <= entry_i.has_pre;
        idx_q <= 2'd0;
      end else if (step) begin
        if (done) begin
          act_q <= 1'b0;
          idx_q <= 2'd0;
        end else if (pre_q && idx_q == ReplEnc.cnt_m1) begin
          pre_q <= 1'b0;
          idx_q <= 2'd0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cpv_q  <= entry_i.has_cp;
      last_q <= entry_i.last;
      enc_q  <= enc_in;
    end
    if (step) begin
      od_q.out_byte  <= byte_sel;
      od_q.last_byte <= flag;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

>>> dv/tb_utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_transcoder
// Self-checking testbench for the UTF-16 to UTF-8 transcoder. A directed
// table covers code point range edges, surrogate pairing and every U+FFFD
// case. Random strings follow in phases that change swap_bytes and the
// handshake idling. Every output byte is checked in order against the table
// or against a local transcoder model.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u16tu8_pkg::*;

  localparam int DrainCycles = 8;   // idle gap before a swap_bytes write
  localparam int TailCycles  = 16;  // watch for stray bytes at the end
  localparam int UnitsPerPhase = 90;

  typedef struct {
    bit          sw;
    in_item_t    item;
    int          n_exp;   // -1: take the bytes from the model
    logic [47:0] want;    // right-aligned, first byte most significant
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // transcoder model state
  bit          swap_on;
  bit          lead_held;
  logic [9:0]  lead_bits;
  out_item_t   utf8_step[$];   // bytes of the latest unit
  out_item_t   exp_utf8[$];    // bytes still owed by the block

  int send_idle_pct;
  int stall_pct;
  int n_fail;
  dir_row_t dir_tab[$];

  utf16_to_utf8_transcoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void push_byte(logic [7:0] v);
    out_item_t b;
    b.out_byte  = v;
    b.last_byte = 1'b0;
    utf8_step.insert(utf8_step.size(), b);
  endfunction

  function automatic void put_code_point(logic [20:0] cp);
    if (cp <= 21'h7f) begin
      push_byte(cp[7:0]);
    end else if (cp <= 21'h7ff) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'hffff) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Advances the model by one code unit; bytes land in utf8_step.
  function automatic void transcode_unit(in_item_t it);
    logic [15:0] u;
    logic        is_lead;
    logic        is_trail;
    utf8_step.delete();
    u = swap_on ? {it.code_unit[7:0], it.code_unit[15:8]} : it.code_unit;
    is_lead  = (u[15:10] == LeadPrefix);
    is_trail = (u[15:10] == TrailPrefix);
    if (lead_held) begin
      lead_held = 1'b0;
      if (is_trail) begin
        put_code_point(SuppBase + {1'b0, lead_bits, u[9:0]});
        lead_bits = '0;
        if (it.last_unit) utf8_step[utf8_step.size()-1].last_byte = 1'b1;
        return;
      end
      lead_bits = '0;
      put_code_point(Replacement);   // unpaired lead flushed first
    end
    if (is_lead && !it.last_unit) begin
      lead_held = 1'b1;
      lead_bits = u[9:0];
      return;
    end
    if (is_lead || is_trail) put_code_point(Replacement);
    else put_code_point({5'b0, u});
    if (it.last_unit && utf8_step.size() > 0)
      utf8_step[utf8_step.size()-1].last_byte = 1'b1;
  endfunction

  function automatic void add_row(bit sw, logic [15:0] cu, bit lu, int n, logic [47:0] want);
    dir_row_t r;
    r.sw             = sw;
    r.item.code_unit = cu;
    r.item.last_unit = lu;
    r.n_exp          = n;
    r.want           = want;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_unit(input in_item_t it, input int n_exp, input logic [47:0] want);
    out_item_t b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    transcode_unit(it);
    if (n_exp < 0) begin
      foreach (utf8_step[k]) exp_utf8.insert(exp_utf8.size(), utf8_step[k]);
    end else begin
      for (int k = 0; k < n_exp; k++) begin
        b.out_byte  = want[8*(n_exp-1-k) +: 8];
        b.last_byte = it.last_unit && (k == n_exp - 1);
        exp_utf8.insert(exp_utf8.size(), b);
      end
    end
    @(negedge clk_i);
  endtask

  task automatic send_logical(input logic [15:0] u, input bit last);
    in_item_t it;
    it.code_unit = swap_on ? {u[7:0], u[15:8]} : u;
    it.last_unit = last;
    send_unit(it, -1, '0);
  endtask

  // Written only with nothing in flight.
  task automatic set_swap(input bit v);
    in_valid_i <= 1'b0;
    while (exp_utf8.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    swap_on = v;
  endtask

  function automatic logic [15:0] rand_scalar();
    logic [15:0] r;
    case ($urandom_range(2))
      0: r = 16'($urandom_range(16'h007f));
      1: r = 16'($urandom_range(16'h07ff, 16'h0080));
      default: begin
        r = 16'($urandom_range(16'hf7ff, 16'h0800));
        if (r >= 16'hd800) r = r + 16'h0800;   // step over the surrogate block
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rand_lead();
    return 16'hd800 | 16'($urandom_range(1023));
  endfunction

  function automatic logic [15:0] rand_trail();
    return 16'hdc00 | 16'($urandom_range(1023));
  endfunction

  function automatic bit rand_last();
    return ($urandom_range(7) == 0);
  endfunction

  task automatic send_random(input int target);
    int sent;
    int kind;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        send_logical(rand_scalar(), rand_last());
        sent += 1;
      end else if (kind < 70) begin
        send_logical(rand_lead(), $urandom_range(15) == 0);
        send_logical(rand_trail(), rand_last());
        sent += 2;
      end else if (kind < 80) begin
        send_logical(16'($urandom), rand_last());
        sent += 1;
      end else if (kind < 88) begin
        send_logical(rand_trail(), rand_last());
        sent += 1;
      end else if (kind < 96) begin
        // lead broken by a scalar or by another lead
        send_logical(rand_lead(), 1'b0);
        send_logical($urandom_range(1) ? rand_lead() : rand_scalar(), rand_last());
        sent += 2;
      end else begin
        send_logical(rand_lead(), 1'b1);
        sent += 1;
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin : chk_utf8
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_utf8.size() == 0) begin
        $error("out_byte: no byte expected, actual %h", out_data_o.out_byte);
        n_fail++;
      end else begin
        want = exp_utf8.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_data_o.out_byte);
          n_fail++;
        end
        if (out_data_o.last_byte !== want.last_byte) begin
          $error("last_byte: expected %b, actual %b", want.last_byte, out_data_o.last_byte);
          n_fail++;
        end
      end
    end
  end

  initial begin
    swap_on       = 1'b0;
    lead_held     = 1'b0;
    lead_bits     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    n_fail        = 0;

    // range edges, pairs and every replacement case
    add_row(0, 16'h0000, 0, 1, 48'h00);
    add_row(0, 16'h007f, 1, 1, 48'h7f);
    add_row(0, 16'h0080, 0, 2, 48'hc280);
    add_row(0, 16'h07ff, 0, 2, 48'hdfbf);
    add_row(0, 16'h0800, 0, 3, 48'he0a080);
    add_row(0, 16'hffff, 1, 3, 48'hefbfbf);
    add_row(0, 16'hd800, 0, 0, 48'h0);
    add_row(0, 16'hdc00, 0, 4, 48'hf0908080);
    add_row(0, 16'hdbff, 0, 0, 48'h0);
    add_row(0, 16'hdfff, 1, 4, 48'hf48fbfbf);
    add_row(0, 16'hdc00, 0, 3, 48'hefbfbd);     // lone trail
    add_row(0, 16'hd800, 1, 3, 48'hefbfbd);     // lead on last unit
    add_row(0, 16'hdabc, 0, 0, 48'h0);
    add_row(0, 16'h0041, 0, 4, 48'hefbfbd41);   // lead broken by scalar
    add_row(0, 16'hd801, 0, 0, 48'h0);
    add_row(0, 16'hdbff, 1, 6, 48'hefbfbdefbfbd);
    add_row(0, 16'hd834, 0, -1, '0);
    add_row(0, 16'hdd1e, 1, -1, '0);
    add_row(0, 16'hd83d, 0, 0, 48'h0);
    add_row(0, 16'hd83e, 0, 3, 48'hefbfbd);     // lead replaces held lead
    add_row(0, 16'hde00, 1, -1, '0);
    add_row(1, 16'h4100, 1, 1, 48'h41);
    add_row(1, 16'h3dd8, 0, 0, 48'h0);
    add_row(1, 16'h00de, 1, -1, '0);
    add_row(1, 16'hacde, 0, 3, 48'hefbfbd);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].sw != swap_on) set_swap(dir_tab[i].sw);
      send_unit(dir_tab[i].item, dir_tab[i].n_exp, dir_tab[i].want);
    end

    // swap setting, sender idle %, receiver stall %
    set_swap(1'b0);
    send_idle_pct = 0;  stall_pct = 0;
    send_random(UnitsPerPhase);

    set_swap(1'b1);
    send_idle_pct = 72; stall_pct = 0;
    send_random(UnitsPerPhase);

    set_swap(1'b0);
    send_idle_pct = 0;  stall_pct = 72;
    send_random(UnitsPerPhase);

    set_swap(1'b1);
    send_idle_pct = 16; stall_pct = 16;
    send_random(UnitsPerPhase);

    in_valid_i <= 1'b0;
    while (exp_utf8.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/u16tu8_pkg.sv
rtl/u16tu8_front.sv
rtl/u16tu8_fifo.sv
rtl/u16tu8_back.sv
rtl/utf16_to_utf8_transcoder.sv
dv/tb_utf16_to_utf8_transcoder.sv
